// File: rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// condition holds in the same cycle
`define VSL_ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("%m: implication check failed");
// condition holds in the next cycle
`define VSL_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("%m: next cycle check failed");
`else
`define VSL_ASSERT_IMPLY(label, clk, rst, pre, post)
`define VSL_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

// File: rtl/vsl_pkg.sv
package vsl_pkg;

   // field and datapath widths
   localparam int DATA_WIDTH    = 16;
   localparam int BLEND_WIDTH   = 17;
   localparam int OUT_WIDTH     = 16;
   localparam int CORDIC_STAGES = 16;
   localparam int VEC_WIDTH     = 36;
   localparam int UNIT_WIDTH    = 32;
   localparam int ROT_WIDTH     = 34;
   localparam int NORM_BITS     = 20;
   localparam int KSHIFT_BITS   = $clog2(VEC_WIDTH - NORM_BITS + 1);
   localparam int LEN_BITS      = 2 * NORM_BITS + 2;
   localparam int QUOT_SHIFT    = 40;
   localparam int WIDE          = 64;
   localparam int ROOT_STEPS    = 32;
   localparam int QUOT_STEPS    = 32;
   localparam int STEP_BITS     = 5;
   localparam int UNIT_LAT      = 4 + ROOT_STEPS + QUOT_STEPS + 1;

   // fixed point constants
   localparam logic [BLEND_WIDTH-1:0]      BLEND_ONE   = 17'd65536;
   localparam logic signed [ROT_WIDTH-1:0] ONE_Q30     = 34'sd1073741824;
   localparam logic signed [ROT_WIDTH-1:0] PI_Q30      = 34'sd3373259426;
   localparam logic signed [ROT_WIDTH-1:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic [WIDE-1:0]             ONE_SQ_Q60  = 64'h1000_0000_0000_0000;

   // rotator modes
   localparam logic ROT_VECTOR = 1'b0;
   localparam logic ROT_ROTATE = 1'b1;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] start_x;
      logic signed [DATA_WIDTH-1:0] start_y;
      logic signed [DATA_WIDTH-1:0] start_z;
      logic signed [DATA_WIDTH-1:0] end_x;
      logic signed [DATA_WIDTH-1:0] end_y;
      logic signed [DATA_WIDTH-1:0] end_z;
      logic [BLEND_WIDTH-1:0]       blend;
   } req_type;

   typedef struct packed {
      logic signed [OUT_WIDTH-1:0] out_x;
      logic signed [OUT_WIDTH-1:0] out_y;
      logic signed [OUT_WIDTH-1:0] out_z;
      logic                        degenerate;
   } rsp_type;

   typedef struct packed {
      logic [WIDE-1:0] rem;
      logic [WIDE-1:0] root;
   } root_type;

   typedef struct packed {
      logic [WIDE-1:0]       rem;
      logic [UNIT_WIDTH-1:0] quo;
      logic [UNIT_WIDTH-1:0] dvs;
   } quot_type;

   typedef struct packed {
      logic signed [ROT_WIDTH-1:0] x;
      logic signed [ROT_WIDTH-1:0] y;
      logic signed [ROT_WIDTH-1:0] z;
   } rot_type;

   // arctangent of 2^-i in Q.30
   function automatic logic [31:0] atan_q30(input logic [STEP_BITS-1:0] i);
      logic [31:0] a;
      unique case (i)
         5'd0:  a = 32'h3243F6A8;
         5'd1:  a = 32'h1DAC6705;
         5'd2:  a = 32'h0FADBAFC;
         5'd3:  a = 32'h07F56EA6;
         5'd4:  a = 32'h03FEAB76;
         5'd5:  a = 32'h01FFD55B;
         5'd6:  a = 32'h00FFFAAA;
         5'd7:  a = 32'h007FFF55;
         5'd8:  a = 32'h003FFFEA;
         5'd9:  a = 32'h001FFFFD;
         5'd10: a = 32'h000FFFFF;
         5'd11: a = 32'h0007FFFF;
         5'd12: a = 32'h0003FFFF;
         5'd13: a = 32'h0001FFFF;
         5'd14: a = 32'h0000FFFF;
         5'd15: a = 32'h00007FFF;
         5'd16: a = 32'h00003FFF;
         5'd17: a = 32'h00001FFF;
         5'd18: a = 32'h00000FFF;
         5'd19: a = 32'h000007FF;
         5'd20: a = 32'h000003FF;
         5'd21: a = 32'h000001FF;
         5'd22: a = 32'h000000FF;
         5'd23: a = 32'h0000007F;
         5'd24: a = 32'h0000003F;
         5'd25: a = 32'h0000001F;
         5'd26: a = 32'h0000000F;
         5'd27: a = 32'h00000008;
         5'd28: a = 32'h00000004;
         5'd29: a = 32'h00000002;
         5'd30: a = 32'h00000001;
         5'd31: a = 32'h00000000;
      endcase
      return a;
   endfunction

endpackage

// File: rtl/vsl_root_cell.sv
module vsl_root_cell (
   input  logic                           clock,
   input  logic                           adv,
   input  logic [vsl_pkg::STEP_BITS-1:0]  step,
   input  vsl_pkg::root_type              up_data,
   output vsl_pkg::root_type              dn_data
);
   import vsl_pkg::*;

   root_type        data_ff;
   root_type        data_in;
   logic [WIDE-1:0] bit_w;
   logic [WIDE-1:0] trial;

   // one digit pair of the floor square root
   always_comb begin
      bit_w   = 64'd1 << (7'd62 - {1'b0, step, 1'b0});
      trial   = up_data.root + bit_w;
      data_in = up_data;
      if (up_data.rem >= trial) begin
         data_in.rem  = up_data.rem - trial;
         data_in.root = (up_data.root >> 1) + bit_w;
      end else begin
         data_in.root = up_data.root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         data_ff <= data_in;
      end
   end

   assign dn_data = data_ff;

endmodule

// File: rtl/vsl_quot_cell.sv
module vsl_quot_cell (
   input  logic                           clock,
   input  logic                           adv,
   input  logic [vsl_pkg::STEP_BITS-1:0]  step,
   input  vsl_pkg::quot_type              up_data,
   output vsl_pkg::quot_type              dn_data
);
   import vsl_pkg::*;

   quot_type        data_ff;
   quot_type        data_in;
   logic [WIDE-1:0] dd;

   // one restoring quotient bit
   always_comb begin
      dd      = {{(WIDE-UNIT_WIDTH){1'b0}}, up_data.dvs} << step;
      data_in = up_data;
      if (up_data.rem >= dd) begin
         data_in.rem = up_data.rem - dd;
         data_in.quo = up_data.quo | (UNIT_WIDTH'(1) << step);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         data_ff <= data_in;
      end
   end

   assign dn_data = data_ff;

endmodule

// File: rtl/vsl_rot_cell.sv
module vsl_rot_cell (
   input  logic                           clock,
   input  logic                           adv,
   input  logic                           mode,
   input  logic [vsl_pkg::STEP_BITS-1:0]  step,
   input  vsl_pkg::rot_type               up_data,
   output vsl_pkg::rot_type               dn_data
);
   import vsl_pkg::*;

   rot_type                     data_ff;
   rot_type                     data_in;
   logic signed [ROT_WIDTH-1:0] dx;
   logic signed [ROT_WIDTH-1:0] dy;
   logic signed [ROT_WIDTH-1:0] at;
   logic                        add_dir;

   // one cordic micro-rotation, vectoring or rotating
   always_comb begin
      dx = up_data.y >>> step;
      dy = up_data.x >>> step;
      at = $signed({{(ROT_WIDTH-32){1'b0}}, atan_q30(step)});
      add_dir = (mode == ROT_VECTOR) ? !up_data.y[ROT_WIDTH-1] : up_data.z[ROT_WIDTH-1];
      data_in.x = add_dir ? up_data.x + dx : up_data.x - dx;
      data_in.y = add_dir ? up_data.y - dy : up_data.y + dy;
      data_in.z = add_dir ? up_data.z + at : up_data.z - at;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         data_ff <= data_in;
      end
   end

   assign dn_data = data_ff;

endmodule

// File: rtl/vsl_unit.sv
module vsl_unit (
   input  logic                                   clock,
   input  logic                                   adv,
   input  logic [2:0][vsl_pkg::VEC_WIDTH-1:0]     vec,
   output logic [2:0][vsl_pkg::UNIT_WIDTH-1:0]    unit_vec,
   output logic                                   nonzero
);
   import vsl_pkg::*;

   typedef struct packed {
      logic [2:0][NORM_BITS-1:0] sh;
      logic [2:0]                neg;
      logic                      ok;
   } rside_type;

   typedef struct packed {
      logic [2:0] neg;
      logic       ok;
   } qside_type;

   logic [2:0][VEC_WIDTH-1:0]   mag_ff;
   logic [2:0]                  neg0_ff;
   logic [2:0]                  neg1_ff;
   logic [2:0]                  neg2_ff;
   logic [VEC_WIDTH-1:0]        mag_or;
   logic [KSHIFT_BITS-1:0]      shift_k;
   logic [2:0][NORM_BITS-1:0]   sh1_ff;
   logic [2:0][NORM_BITS-1:0]   sh2_ff;
   logic [2:0][2*NORM_BITS-1:0] sq_ff;
   logic [LEN_BITS-1:0]         len_ff;
   rside_type                   side3_ff;
   rside_type                   rside_ff [ROOT_STEPS];
   qside_type                   qside_ff [QUOT_STEPS];
   root_type                    root_chain [ROOT_STEPS+1];
   quot_type                    quot_chain [3][QUOT_STEPS+1];
   logic [UNIT_WIDTH-1:0]       root_w;
   logic [2:0][UNIT_WIDTH-1:0]  unit_ff;
   logic                        ok_ff;

   // magnitudes and signs
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            neg0_ff[i] <= vec[i][VEC_WIDTH-1];
            mag_ff[i]  <= vec[i][VEC_WIDTH-1] ? (~vec[i] + 1'b1) : vec[i];
         end
      end
   end

   // right shift that brings the largest magnitude below 2^20
   assign mag_or = mag_ff[0] | mag_ff[1] | mag_ff[2];

   always_comb begin
      shift_k = '0;
      for (int b = NORM_BITS; b < VEC_WIDTH; b++) begin
         if (mag_or[b]) begin
            shift_k = KSHIFT_BITS'(b - NORM_BITS + 1);
         end
      end
   end

   // shift, square, sum
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            sh1_ff[i] <= NORM_BITS'(mag_ff[i] >> shift_k);
            sq_ff[i]  <= sh1_ff[i] * sh1_ff[i];
         end
         neg1_ff     <= neg0_ff;
         sh2_ff      <= sh1_ff;
         neg2_ff     <= neg1_ff;
         len_ff      <= LEN_BITS'(sq_ff[0]) + LEN_BITS'(sq_ff[1]) + LEN_BITS'(sq_ff[2]);
         side3_ff.sh <= sh2_ff;
         side3_ff.neg <= neg2_ff;
         side3_ff.ok <= (sq_ff[0] | sq_ff[1] | sq_ff[2]) != '0;
      end
   end

   // square root of the length squared, one cell per digit pair
   assign root_chain[0].rem  = {{(WIDE-LEN_BITS-NORM_BITS){1'b0}}, len_ff, {NORM_BITS{1'b0}}};
   assign root_chain[0].root = '0;

   for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
      vsl_root_cell u_cell (
         .clock   (clock),
         .adv     (adv),
         .step    (STEP_BITS'(k)),
         .up_data (root_chain[k]),
         .dn_data (root_chain[k+1])
      );
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rside_ff[0] <= side3_ff;
         for (int k = 1; k < ROOT_STEPS; k++) begin
            rside_ff[k] <= rside_ff[k-1];
         end
      end
   end

   assign root_w = root_chain[ROOT_STEPS].root[UNIT_WIDTH-1:0];

   // one divider chain per component
   for (genvar i = 0; i < 3; i++) begin : g_lane
      assign quot_chain[i][0].rem = {{(WIDE-NORM_BITS-QUOT_SHIFT){1'b0}},
                                     rside_ff[ROOT_STEPS-1].sh[i], {QUOT_SHIFT{1'b0}}};
      assign quot_chain[i][0].quo = '0;
      assign quot_chain[i][0].dvs = root_w;
      for (genvar k = 0; k < QUOT_STEPS; k++) begin : g_quot
         vsl_quot_cell u_cell (
            .clock   (clock),
            .adv     (adv),
            .step    (STEP_BITS'(QUOT_STEPS - 1 - k)),
            .up_data (quot_chain[i][k]),
            .dn_data (quot_chain[i][k+1])
         );
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         qside_ff[0].neg <= rside_ff[ROOT_STEPS-1].neg;
         qside_ff[0].ok  <= rside_ff[ROOT_STEPS-1].ok;
         for (int k = 1; k < QUOT_STEPS; k++) begin
            qside_ff[k] <= qside_ff[k-1];
         end
      end
   end

   // reapply the signs
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            unit_ff[i] <= qside_ff[QUOT_STEPS-1].neg[i] ?
                          (~quot_chain[i][QUOT_STEPS].quo + 1'b1) :
                          quot_chain[i][QUOT_STEPS].quo;
         end
         ok_ff <= qside_ff[QUOT_STEPS-1].ok;
      end
   end

   assign unit_vec = unit_ff;
   assign nonzero  = ok_ff;

endmodule

// File: rtl/vector_slerp_unit.sv
// channel   direction  handshake              payload
// req       in         req_valid / req_ready  req_data  (vsl_pkg::req_type)
// rsp       out        rsp_valid / rsp_ready  rsp_data  (vsl_pkg::rsp_type)
//
// one item per cycle while no result is held at rsp
// depth is set by two normalizers in series (each 32 root cells and 32
// divider cells), the 32 cell root for the angle sine and the 16 cell angle
// and sine cordic rows
// reset clears only the valid bits of the pipeline
// a result held at rsp freezes the whole pipeline and drops req_ready
`include "assert_macros.svh"

module vector_slerp_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  vsl_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output vsl_pkg::rsp_type  rsp_data
);
   import vsl_pkg::*;

   localparam int PIPE_DEPTH = 2 * UNIT_LAT + 3 + ROOT_STEPS + 2 * CORDIC_STAGES + 6;

   typedef struct packed {
      logic [2:0][UNIT_WIDTH-1:0] su;
      logic [2:0][UNIT_WIDTH-1:0] eu;
      logic                       sok;
      logic                       eok;
      logic                       nz;
      logic [BLEND_WIDTH-1:0]     blend;
      logic [UNIT_WIDTH-1:0]      dot;
   } side_type;

   logic                          adv;
   logic [PIPE_DEPTH-1:0]         valid_ff;
   logic [PIPE_DEPTH-1:0]         valid_in;
   logic [2:0][VEC_WIDTH-1:0]     svec;
   logic [2:0][VEC_WIDTH-1:0]     evec;
   logic [2:0][UNIT_WIDTH-1:0]    su_w;
   logic [2:0][UNIT_WIDTH-1:0]    eu_w;
   logic                          sok_w;
   logic                          eok_w;
   logic [BLEND_WIDTH-1:0]        blend_sat;
   logic [BLEND_WIDTH-1:0]        bl_ff [UNIT_LAT];
   side_type                      side1_ff;
   side_type                      side2_ff;
   side_type                      side2_in;
   side_type                      side3_ff;
   side_type                      rs_ff [ROOT_STEPS];
   side_type                      rot_head_side;
   side_type                      ts_ff [CORDIC_STAGES];
   side_type                      side_m_ff;
   side_type                      side_f_ff;
   side_type                      ss_ff [CORDIC_STAGES];
   side_type                      side_c1_ff;
   side_type                      side_c2_ff;
   side_type                      us_ff [UNIT_LAT];
   logic signed [WIDE-1:0]        prod_ff [3];
   logic signed [WIDE+1:0]        dsum;
   logic signed [WIDE+1:0]        dshift;
   logic [UNIT_WIDTH-1:0]         dot_c;
   logic [WIDE-1:0]               dsq_ff;
   root_type                      root_chain [ROOT_STEPS+1];
   logic [UNIT_WIDTH-1:0]         s0_w;
   logic signed [ROT_WIDTH-1:0]   dot_x;
   rot_type                       ang_chain [CORDIC_STAGES+1];
   rot_type                       sin1_chain [CORDIC_STAGES+1];
   rot_type                       sin2_chain [CORDIC_STAGES+1];
   logic signed [ROT_WIDTH-1:0]   ang_z;
   logic [UNIT_WIDTH-1:0]         theta;
   logic [UNIT_WIDTH+BLEND_WIDTH-1:0] m1;
   logic [UNIT_WIDTH+BLEND_WIDTH-1:0] m2;
   logic [UNIT_WIDTH-1:0]         arg1_ff;
   logic [UNIT_WIDTH-1:0]         arg2_ff;
   logic signed [ROT_WIDTH-1:0]   fold1_ff;
   logic signed [ROT_WIDTH-1:0]   fold2_ff;
   logic [UNIT_WIDTH-1:0]         w1;
   logic [UNIT_WIDTH-1:0]         w2;
   logic signed [WIDE-1:0]        p1_ff [3];
   logic signed [WIDE-1:0]        p2_ff [3];
   logic signed [WIDE:0]          csum [3];
   logic [2:0][VEC_WIDTH-1:0]     cv_ff;
   logic [2:0][UNIT_WIDTH-1:0]    cu_w;
   logic                          cok_w;
   logic [2:0][UNIT_WIDTH-1:0]    res;
   logic                          deg;
   logic [2:0][UNIT_WIDTH-1:0]    f_mag_ff;
   logic [2:0]                    f_neg_ff;
   logic                          f_deg_ff;
   logic [2:0][OUT_WIDTH-1:0]     rnd;
   rsp_type                       rsp_ff;
   rsp_type                       rsp_in;
   logic                          rsp_zero;
   logic                          rsp_in_range;

   // global stall: everything moves when the output slot is free or taken
   assign adv       = !valid_ff[PIPE_DEPTH-1] || rsp_ready;
   assign req_ready = adv;
   assign valid_in  = {valid_ff[PIPE_DEPTH-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   // normalize start and end vectors
   assign svec[0] = {{(VEC_WIDTH-DATA_WIDTH){req_data.start_x[DATA_WIDTH-1]}}, req_data.start_x};
   assign svec[1] = {{(VEC_WIDTH-DATA_WIDTH){req_data.start_y[DATA_WIDTH-1]}}, req_data.start_y};
   assign svec[2] = {{(VEC_WIDTH-DATA_WIDTH){req_data.start_z[DATA_WIDTH-1]}}, req_data.start_z};
   assign evec[0] = {{(VEC_WIDTH-DATA_WIDTH){req_data.end_x[DATA_WIDTH-1]}}, req_data.end_x};
   assign evec[1] = {{(VEC_WIDTH-DATA_WIDTH){req_data.end_y[DATA_WIDTH-1]}}, req_data.end_y};
   assign evec[2] = {{(VEC_WIDTH-DATA_WIDTH){req_data.end_z[DATA_WIDTH-1]}}, req_data.end_z};

   vsl_unit u_start_unit (
      .clock    (clock),
      .adv      (adv),
      .vec      (svec),
      .unit_vec (su_w),
      .nonzero  (sok_w)
   );

   vsl_unit u_end_unit (
      .clock    (clock),
      .adv      (adv),
      .vec      (evec),
      .unit_vec (eu_w),
      .nonzero  (eok_w)
   );

   // saturated blend rides alongside the normalizers
   assign blend_sat = (req_data.blend > BLEND_ONE) ? BLEND_ONE : req_data.blend;

   always_ff @(posedge clock) begin
      if (adv) begin
         bl_ff[0] <= blend_sat;
         for (int k = 1; k < UNIT_LAT; k++) begin
            bl_ff[k] <= bl_ff[k-1];
         end
      end
   end

   // dot product terms
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            prod_ff[i] <= $signed(su_w[i]) * $signed(eu_w[i]);
         end
         side1_ff.su    <= su_w;
         side1_ff.eu    <= eu_w;
         side1_ff.sok   <= sok_w;
         side1_ff.eok   <= eok_w;
         side1_ff.nz    <= 1'b0;
         side1_ff.blend <= bl_ff[UNIT_LAT-1];
         side1_ff.dot   <= '0;
      end
   end

   // sum, scale and clamp the dot product
   always_comb begin
      dsum   = prod_ff[0] + prod_ff[1] + prod_ff[2];
      dshift = dsum >>> 30;
      priority if (dshift > ONE_Q30) begin
         dot_c = ONE_Q30[UNIT_WIDTH-1:0];
      end else if (dshift < -ONE_Q30) begin
         dot_c = UNIT_WIDTH'(-ONE_Q30);
      end else begin
         dot_c = dshift[UNIT_WIDTH-1:0];
      end
      side2_in     = side1_ff;
      side2_in.dot = dot_c;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side2_ff <= side2_in;
         dsq_ff   <= $signed(side2_ff.dot) * $signed(side2_ff.dot);
         side3_ff <= side2_ff;
      end
   end

   // sine of the angle as sqrt(1 - dot^2)
   assign root_chain[0].rem  = ONE_SQ_Q60 - dsq_ff;
   assign root_chain[0].root = '0;

   for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
      vsl_root_cell u_cell (
         .clock   (clock),
         .adv     (adv),
         .step    (STEP_BITS'(k)),
         .up_data (root_chain[k]),
         .dn_data (root_chain[k+1])
      );
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rs_ff[0] <= side3_ff;
         for (int k = 1; k < ROOT_STEPS; k++) begin
            rs_ff[k] <= rs_ff[k-1];
         end
      end
   end

   // angle from (dot, sine); quarter turn first when dot is negative
   assign s0_w  = root_chain[ROOT_STEPS].root[UNIT_WIDTH-1:0];
   assign dot_x = {{(ROT_WIDTH-UNIT_WIDTH){rs_ff[ROOT_STEPS-1].dot[UNIT_WIDTH-1]}},
                   rs_ff[ROOT_STEPS-1].dot};

   always_comb begin
      if (dot_x[ROT_WIDTH-1]) begin
         ang_chain[0].x = {{(ROT_WIDTH-UNIT_WIDTH){1'b0}}, s0_w};
         ang_chain[0].y = -dot_x;
         ang_chain[0].z = HALF_PI_Q30;
      end else begin
         ang_chain[0].x = dot_x;
         ang_chain[0].y = {{(ROT_WIDTH-UNIT_WIDTH){1'b0}}, s0_w};
         ang_chain[0].z = '0;
      end
      rot_head_side    = rs_ff[ROOT_STEPS-1];
      rot_head_side.nz = (s0_w != '0);
   end

   for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_angle
      vsl_rot_cell u_cell (
         .clock   (clock),
         .adv     (adv),
         .mode    (ROT_VECTOR),
         .step    (STEP_BITS'(k)),
         .up_data (ang_chain[k]),
         .dn_data (ang_chain[k+1])
      );
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ts_ff[0] <= rot_head_side;
         for (int k = 1; k < CORDIC_STAGES; k++) begin
            ts_ff[k] <= ts_ff[k-1];
         end
      end
   end

   // clamp theta to [0, pi] and scale by (1 - t) and t
   assign ang_z = ang_chain[CORDIC_STAGES].z;

   always_comb begin
      priority if (ang_z < 0) begin
         theta = '0;
      end else if (ang_z > PI_Q30) begin
         theta = PI_Q30[UNIT_WIDTH-1:0];
      end else begin
         theta = ang_z[UNIT_WIDTH-1:0];
      end
      m1 = theta * (BLEND_ONE - ts_ff[CORDIC_STAGES-1].blend);
      m2 = theta * ts_ff[CORDIC_STAGES-1].blend;
   end

   // fold the sine arguments into the first quadrant
   always_ff @(posedge clock) begin
      if (adv) begin
         arg1_ff   <= m1[UNIT_WIDTH+15:16];
         arg2_ff   <= m2[UNIT_WIDTH+15:16];
         side_m_ff <= ts_ff[CORDIC_STAGES-1];
         fold1_ff  <= ($signed({2'b00, arg1_ff}) > HALF_PI_Q30) ?
                      (PI_Q30 - $signed({2'b00, arg1_ff})) : $signed({2'b00, arg1_ff});
         fold2_ff  <= ($signed({2'b00, arg2_ff}) > HALF_PI_Q30) ?
                      (PI_Q30 - $signed({2'b00, arg2_ff})) : $signed({2'b00, arg2_ff});
         side_f_ff <= side_m_ff;
      end
   end

   // weight sines
   assign sin1_chain[0].x = ONE_Q30;
   assign sin1_chain[0].y = '0;
   assign sin1_chain[0].z = fold1_ff;
   assign sin2_chain[0].x = ONE_Q30;
   assign sin2_chain[0].y = '0;
   assign sin2_chain[0].z = fold2_ff;

   for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_sine
      vsl_rot_cell u_cell1 (
         .clock   (clock),
         .adv     (adv),
         .mode    (ROT_ROTATE),
         .step    (STEP_BITS'(k)),
         .up_data (sin1_chain[k]),
         .dn_data (sin1_chain[k+1])
      );
      vsl_rot_cell u_cell2 (
         .clock   (clock),
         .adv     (adv),
         .mode    (ROT_ROTATE),
         .step    (STEP_BITS'(k)),
         .up_data (sin2_chain[k]),
         .dn_data (sin2_chain[k+1])
      );
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ss_ff[0] <= side_f_ff;
         for (int k = 1; k < CORDIC_STAGES; k++) begin
            ss_ff[k] <= ss_ff[k-1];
         end
      end
   end

   // weighted sum of the unit vectors
   assign w1 = sin1_chain[CORDIC_STAGES].y[UNIT_WIDTH-1:0];
   assign w2 = sin2_chain[CORDIC_STAGES].y[UNIT_WIDTH-1:0];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         csum[i] = p1_ff[i] + p2_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            p1_ff[i] <= $signed(w1) * $signed(ss_ff[CORDIC_STAGES-1].su[i]);
            p2_ff[i] <= $signed(w2) * $signed(ss_ff[CORDIC_STAGES-1].eu[i]);
            cv_ff[i] <= VEC_WIDTH'(csum[i] >>> 30);
         end
         side_c1_ff <= ss_ff[CORDIC_STAGES-1];
         side_c2_ff <= side_c1_ff;
      end
   end

   vsl_unit u_blend_unit (
      .clock    (clock),
      .adv      (adv),
      .vec      (cv_ff),
      .unit_vec (cu_w),
      .nonzero  (cok_w)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         us_ff[0] <= side_c2_ff;
         for (int k = 1; k < UNIT_LAT; k++) begin
            us_ff[k] <= us_ff[k-1];
         end
      end
   end

   // fallbacks: zero start gives zero, other degenerate cases give the start
   always_comb begin
      priority if (!us_ff[UNIT_LAT-1].sok) begin
         res = '0;
         deg = 1'b1;
      end else if (!us_ff[UNIT_LAT-1].eok || !us_ff[UNIT_LAT-1].nz || !cok_w) begin
         res = us_ff[UNIT_LAT-1].su;
         deg = 1'b1;
      end else begin
         res = cu_w;
         deg = 1'b0;
      end
   end

   // round magnitudes to q1.14 and reapply signs
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rnd[i] = OUT_WIDTH'((f_mag_ff[i] + UNIT_WIDTH'(32768)) >> 16);
      end
      rsp_in.out_x      = f_neg_ff[0] ? -$signed(rnd[0]) : $signed(rnd[0]);
      rsp_in.out_y      = f_neg_ff[1] ? -$signed(rnd[1]) : $signed(rnd[1]);
      rsp_in.out_z      = f_neg_ff[2] ? -$signed(rnd[2]) : $signed(rnd[2]);
      rsp_in.degenerate = f_deg_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            f_neg_ff[i] <= res[i][UNIT_WIDTH-1];
            f_mag_ff[i] <= res[i][UNIT_WIDTH-1] ? (~res[i] + 1'b1) : res[i];
         end
         f_deg_ff <= deg;
         rsp_ff   <= rsp_in;
      end
   end

   assign rsp_valid = valid_ff[PIPE_DEPTH-1];
   assign rsp_data  = rsp_ff;

   // checks
   assign rsp_zero     = (rsp_data.out_x == '0) && (rsp_data.out_y == '0) &&
                         (rsp_data.out_z == '0);
   assign rsp_in_range = (rsp_data.out_x <= 16'sd16384) && (rsp_data.out_x >= -16'sd16384) &&
                         (rsp_data.out_y <= 16'sd16384) && (rsp_data.out_y >= -16'sd16384) &&
                         (rsp_data.out_z <= 16'sd16384) && (rsp_data.out_z >= -16'sd16384);

   `VSL_ASSERT_IMPLY(a_stall_blocks_input, clock, reset, rsp_valid && !rsp_ready, !req_ready)
   `VSL_ASSERT_IMPLY(a_zero_is_degenerate, clock, reset, rsp_valid && rsp_zero, rsp_data.degenerate)
   `VSL_ASSERT_IMPLY(a_unit_range, clock, reset, rsp_valid, rsp_in_range)
   `VSL_ASSERT_NEXT(a_held_result, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

endmodule

// File: test/tb_vector_slerp_unit.sv
module tb_vector_slerp_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import vsl_pkg::*;

   localparam int    STALL_LIMIT = 3000;
   localparam int    PIPE_CYCLES = 211;
   localparam longint Q30_ONE    = 64'sd1073741824;
   localparam longint Q30_PI     = 64'sd3373259426;
   localparam longint Q30_HALFPI = 64'sd1686629713;
   localparam longint unsigned UNIT_BLEND = 64'd65536;

   localparam longint ARCTAN [16] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
      64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
      64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF};

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   rsp_type expected_vectors[$];
   int      mismatches = 0;
   int      hold_cycles = 0;
   bit      calm = 0;
   int      quiet_cycles = 0;

   vector_slerp_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   // 12 ns clock
   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // floor square root
   function automatic longint unsigned int_root(input longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // scale to a q.30 unit vector, zero vector gives 0
   function automatic bit make_unit(input longint v[3], output longint u[3]);
      longint unsigned mag[3];
      longint unsigned m, len2, s;
      int k;
      m = 0;
      len2 = 0;
      k = 0;
      for (int i = 0; i < 3; i++) begin
         mag[i] = v[i] < 0 ? longint'(-v[i]) : longint'(v[i]);
         if (mag[i] > m) m = mag[i];
      end
      while ((m >> k) >= (64'd1 << 20)) k++;
      for (int i = 0; i < 3; i++) begin
         mag[i] = mag[i] >> k;
         len2 = len2 + mag[i] * mag[i];
      end
      for (int i = 0; i < 3; i++) u[i] = 0;
      if (len2 == 0) return 0;
      s = int_root(len2 << 20);
      for (int i = 0; i < 3; i++) begin
         longint q;
         q = longint'((mag[i] << 40) / s);
         u[i] = v[i] < 0 ? -q : q;
      end
      return 1;
   endfunction

   // cordic vectoring: angle of (x, y), y >= 0
   function automatic longint vector_angle(input longint x, input longint y);
      longint z, t, dx, dy;
      z = 0;
      if (x < 0) begin
         t = x;
         x = y;
         y = -t;
         z = Q30_HALFPI;
      end
      for (int i = 0; i < 16; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x += dx;
            y -= dy;
            z += ARCTAN[i];
         end else begin
            x -= dx;
            y += dy;
            z -= ARCTAN[i];
         end
      end
      if (z < 0) z = 0;
      if (z > Q30_PI) z = Q30_PI;
      return z;
   endfunction

   // cordic rotation: sine with gain
   function automatic longint scaled_sine(input longint a);
      longint x, y, dx, dy;
      x = Q30_ONE;
      y = 0;
      if (a > Q30_HALFPI) a = Q30_PI - a;
      for (int i = 0; i < 16; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (a >= 0) begin
            x -= dx;
            y += dy;
            a -= ARCTAN[i];
         end else begin
            x += dx;
            y -= dy;
            a += ARCTAN[i];
         end
      end
      return y;
   endfunction

   // q.30 to q1.14, magnitude rounded half up
   function automatic logic signed [15:0] round_q14(input longint q);
      longint unsigned m;
      longint r;
      m = q < 0 ? longint'(-q) : longint'(q);
      m = (m + 64'd32768) >> 16;
      r = q < 0 ? -longint'(m) : longint'(m);
      return r[15:0];
   endfunction

   function automatic rsp_type slerp_result(input req_type r);
      longint sv[3], ev[3], su[3], eu[3], cv[3], res[3];
      longint dot, theta, w1, w2;
      longint unsigned t, s0;
      bit degen;
      rsp_type o;
      sv = '{longint'(r.start_x), longint'(r.start_y), longint'(r.start_z)};
      ev = '{longint'(r.end_x), longint'(r.end_y), longint'(r.end_z)};
      t = r.blend;
      if (t > UNIT_BLEND) t = UNIT_BLEND;
      degen = 0;
      dot = 0;
      if (!make_unit(sv, su)) begin
         o.out_x = '0;
         o.out_y = '0;
         o.out_z = '0;
         o.degenerate = 1'b1;
         return o;
      end
      res = su;
      if (!make_unit(ev, eu)) begin
         degen = 1;
      end else begin
         for (int i = 0; i < 3; i++) dot += su[i] * eu[i];
         dot = dot >>> 30;
         if (dot > Q30_ONE) dot = Q30_ONE;
         if (dot < -Q30_ONE) dot = -Q30_ONE;
         s0 = int_root(longint'(Q30_ONE * Q30_ONE - dot * dot));
         if (s0 == 0) begin
            degen = 1;
         end else begin
            theta = vector_angle(dot, longint'(s0));
            w1 = scaled_sine(longint'((longint'(theta) * (UNIT_BLEND - t)) >> 16));
            w2 = scaled_sine(longint'((longint'(theta) * t) >> 16));
            for (int i = 0; i < 3; i++) cv[i] = (w1 * su[i] + w2 * eu[i]) >>> 30;
            if (!make_unit(cv, res)) begin
               degen = 1;
               res = su;
            end
         end
      end
      o.out_x = round_q14(res[0]);
      o.out_y = round_q14(res[1]);
      o.out_z = round_q14(res[2]);
      o.degenerate = degen;
      return o;
   endfunction

   // send one item, with an optional random gap before it
   task automatic send_item(input req_type r);
      @(negedge clock);
      if (!calm && $urandom_range(0, 99) < 20) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      expected_vectors.push_back(slerp_result(r));
   endtask

   task automatic stop_sending();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      stop_sending();
      while (expected_vectors.size() != 0) @(posedge clock);
   endtask

   function automatic req_type make_req(input int sx, sy, sz, ex, ey, ez, input int bl);
      req_type r;
      r.start_x = sx[15:0];
      r.start_y = sy[15:0];
      r.start_z = sz[15:0];
      r.end_x   = ex[15:0];
      r.end_y   = ey[15:0];
      r.end_z   = ez[15:0];
      r.blend   = bl[16:0];
      return r;
   endfunction

   function automatic int rand_comp(input int mode);
      case (mode)
         0: return $urandom_range(0, 65535) - 32768;
         1: return $urandom_range(0, 64) - 32;
         default: return $urandom_range(0, 8191) - 4096;
      endcase
   endfunction

   function automatic int rand_blend();
      int p;
      p = $urandom_range(0, 99);
      if (p < 70) return $urandom_range(0, 65536);
      if (p < 80) return 0;
      if (p < 90) return 65536;
      return $urandom_range(65537, 131071);
   endfunction

   function automatic req_type rand_req();
      req_type r;
      int p, m, sx, sy, sz;
      p = $urandom_range(0, 99);
      m = $urandom_range(0, 2);
      sx = rand_comp(m);
      sy = rand_comp(m);
      sz = rand_comp(m);
      if (p < 60) begin
         r = make_req(sx, sy, sz, rand_comp(m), rand_comp(m), rand_comp(m), rand_blend());
      end else if (p < 80) begin
         // nearly parallel or antiparallel
         if ($urandom_range(0, 1))
            r = make_req(sx, sy, sz, sx + rand_comp(1) / 8, sy + rand_comp(1) / 8,
                         sz, rand_blend());
         else
            r = make_req(sx, sy, sz, -sx + rand_comp(1) / 8, -sy, -sz, rand_blend());
      end else if (p < 90) begin
         // scaled copies: start is the end halved, rounded toward zero
         r = make_req(sx / 2, sy / 2, sz / 2, sx, sy, sz, rand_blend());
      end else begin
         // zero components
         r = make_req(p[0] ? 0 : sx, p[1] ? 0 : sy, p[2] ? 0 : sz,
                      p[1] ? 0 : rand_comp(m), p[2] ? 0 : rand_comp(m), 0, rand_blend());
      end
      return r;
   endfunction

   task automatic test_directed();
      send_item(make_req(32767, 32767, 32767, -32768, -32768, -32768, 32768));
      send_item(make_req(-32768, 0, 0, 0, 32767, 0, 0));
      send_item(make_req(-32768, 0, 0, 0, 32767, 0, 65536));
      send_item(make_req(4096, 0, 0, 0, 4096, 0, 131071));
      send_item(make_req(4096, 0, 0, 0, 4096, 0, 65537));
      send_item(make_req(0, 0, 0, 4096, 4096, 0, 32768));
      send_item(make_req(4096, -4096, 1, 0, 0, 0, 32768));
      send_item(make_req(4096, 4096, 0, 8192, 8192, 0, 20000));
      send_item(make_req(4096, 4096, 0, -4096, -4096, 0, 20000));
      send_item(make_req(4096, 0, 0, -4096, 1, 0, 32768));
      send_item(make_req(-4096, 0, 0, 4096, 1, 0, 32768));
      send_item(make_req(4096, 0, 0, 4096, 1, 0, 1));
      send_item(make_req(1, 0, 0, 0, 1, 0, 32768));
      send_item(make_req(1, 1, 1, -1, -1, 1, 12345));
      send_item(make_req(32767, -32768, 32767, -32768, 32767, -32768, 65535));
      send_item(make_req(0, 0, -32768, 0, -1, -32768, 50000));
      send_item(make_req(0, 0, 1, 0, 0, -1, 65536));
      send_item(make_req(-1, -1, -1, 32767, 0, 0, 98304));
      stop_sending();
   endtask

   task automatic test_random(input int count);
      for (int i = 0; i < count; i++) begin
         calm = (i >= count / 3) && (i < count / 3 + 60);
         send_item(rand_req());
      end
      calm = 0;
      stop_sending();
   endtask

   // receiver holds off while the sender keeps offering items
   task automatic test_backpressure();
      wait_drained();
      hold_cycles = 400;
      calm = 1;
      for (int i = 0; i < 240; i++) send_item(rand_req());
      calm = 0;
      wait_drained();
   endtask

   // receiver
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else if (calm) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= 20);
      end
   end

   // result check
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_vectors.size() == 0) begin
            $error("result item with nothing expected");
            mismatches++;
         end else begin
            want = expected_vectors.pop_front();
            if (rsp_data.out_x !== want.out_x) begin
               $error("out_x expected %0d got %0d", want.out_x, rsp_data.out_x);
               mismatches++;
            end
            if (rsp_data.out_y !== want.out_y) begin
               $error("out_y expected %0d got %0d", want.out_y, rsp_data.out_y);
               mismatches++;
            end
            if (rsp_data.out_z !== want.out_z) begin
               $error("out_z expected %0d got %0d", want.out_z, rsp_data.out_z);
               mismatches++;
            end
            if (rsp_data.degenerate !== want.degenerate) begin
               $error("degenerate expected %0d got %0d", want.degenerate,
                      rsp_data.degenerate);
               mismatches++;
            end
         end
      end
   end

   // watchdog on cycles with no item moving
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_ready = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random(120);
      test_backpressure();
      test_random(72);
      wait_drained();
      repeat (PIPE_CYCLES + 20) @(posedge clock);

      if (mismatches == 0 && expected_vectors.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
